[rtl/pwl_pkg.sv]
// ----------------------------------------------------------------------------
// pwl_pkg - shared types and constants for the piecewise-linear interpolator
// Holds the breakpoint word layout, the operation codes and the command and
// status groups that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package pwl_pkg;

    localparam int MAX_POINTS_DEF = 16;
    localparam int IDX_W          = 4;
    localparam int CFG_W          = 5;
    localparam int DATA_W         = 16;

    // The divider retires two quotient bits per step over a 34-bit dividend.
    localparam int DIV_STEPS = 17;
    localparam int DIV_CNT_W = 5;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_EVAL = 1'b1;

    typedef struct packed {
        logic [DATA_W-1:0] x;
        logic [DATA_W-1:0] y;
    } t_point;

    typedef struct packed {
        logic capture;
        logic load_wr;
        logic ack;
        logic rd_en;
        logic tag_first;
        logic tag_second;
        logic tag_last;
        logic decide;
        logic div_load;
        logic div_step;
        logic fin;
    } t_dp_cmd;

    typedef struct packed {
        logic direct;
    } t_dp_status;

endpackage

[rtl/pwl_ctrl.sv]
// ----------------------------------------------------------------------------
// pwl_ctrl - sequencer for the piecewise-linear interpolator
// Holds the point-count register, walks the table addresses during a scan,
// counts divider steps and issues commands to the datapath.
// ----------------------------------------------------------------------------
module pwl_ctrl #(
    parameter int MAX_POINTS = pwl_pkg::MAX_POINTS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic                       i_op,
    input  logic                       i_cfg_wr_en,
    input  logic [pwl_pkg::CFG_W-1:0]  i_cfg_wr_data,
    input  pwl_pkg::t_dp_status        i_status,
    output pwl_pkg::t_dp_cmd           o_cmd,
    output logic [$clog2(MAX_POINTS)-1:0] o_rd_addr
);

    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_SCAN  = 7'b0000010,
        S_DRAIN = 7'b0000100,
        S_DEC   = 7'b0001000,
        S_LOAD  = 7'b0010000,
        S_DIV   = 7'b0100000,
        S_FIN   = 7'b1000000
    } t_state;

    t_state                          r_state, n_state;
    logic [pwl_pkg::CFG_W-1:0]       r_points;
    logic [AW-1:0]                   r_addr, n_addr;
    logic [pwl_pkg::DIV_CNT_W-1:0]   r_div_cnt, n_div_cnt;
    logic [CW-1:0]                   w_n_eff;
    logic                            w_last;

    // Counts above the table depth are clipped to the depth.
    assign w_n_eff = (32'(r_points) > MAX_POINTS) ? CW'(MAX_POINTS) : CW'(r_points);
    assign w_last  = (r_addr == AW'(w_n_eff - 1'b1));

    always_comb begin
        n_state   = r_state;
        n_addr    = r_addr;
        n_div_cnt = r_div_cnt;
        o_cmd     = '0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    if (i_op == pwl_pkg::OP_LOAD) begin
                        o_cmd.load_wr = 1'b1;
                        o_cmd.ack     = 1'b1;
                    end else begin
                        o_cmd.capture = 1'b1;
                        n_addr        = '0;
                        n_state       = (w_n_eff == '0) ? S_FIN : S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                o_cmd.rd_en      = 1'b1;
                o_cmd.tag_first  = (r_addr == '0);
                o_cmd.tag_second = (r_addr == AW'(1));
                o_cmd.tag_last   = w_last;
                if (w_last) begin
                    n_state = S_DRAIN;
                end else begin
                    n_addr = r_addr + 1'b1;
                end
            end
            S_DRAIN: begin
                n_state = S_DEC;
            end
            S_DEC: begin
                o_cmd.decide = 1'b1;
                n_state      = S_LOAD;
            end
            S_LOAD: begin
                o_cmd.div_load = 1'b1;
                n_div_cnt      = '0;
                n_state        = i_status.direct ? S_FIN : S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (r_div_cnt == pwl_pkg::DIV_CNT_W'(pwl_pkg::DIV_STEPS - 1)) begin
                    n_state = S_FIN;
                end else begin
                    n_div_cnt = r_div_cnt + 1'b1;
                end
            end
            S_FIN: begin
                o_cmd.fin = 1'b1;
                n_state   = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_addr    <= '0;
            r_div_cnt <= '0;
            r_points  <= '0;
        end else begin
            r_state   <= n_state;
            r_addr    <= n_addr;
            r_div_cnt <= n_div_cnt;
            if (i_cfg_wr_en) begin
                r_points <= i_cfg_wr_data;
            end
        end
    end

    assign busy      = (r_state != S_IDLE);
    assign o_rd_addr = r_addr;

endmodule

[rtl/pwl_dpath.sv]
// ----------------------------------------------------------------------------
// pwl_dpath - breakpoint memory, segment search and interpolation arithmetic
// Stores the table, tracks the bracketing segment while entries stream out,
// forms the product and runs a radix-4 restoring divider.
// ----------------------------------------------------------------------------
module pwl_dpath #(
    parameter int MAX_POINTS = pwl_pkg::MAX_POINTS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  pwl_pkg::t_dp_cmd                  i_cmd,
    input  logic [$clog2(MAX_POINTS)-1:0]     i_rd_addr,
    input  logic [pwl_pkg::IDX_W-1:0]         i_point_index,
    input  logic signed [pwl_pkg::DATA_W-1:0] i_point_x,
    input  logic signed [pwl_pkg::DATA_W-1:0] i_point_y,
    input  logic signed [pwl_pkg::DATA_W-1:0] i_query_x,
    output pwl_pkg::t_dp_status               o_status,
    output logic                              o_result_stb,
    output logic signed [pwl_pkg::DATA_W-1:0] o_result_y,
    output logic                              o_is_evaluation
);

    localparam int AW = $clog2(MAX_POINTS);

    pwl_pkg::t_point r_mem [MAX_POINTS];
    pwl_pkg::t_point r_rd_data;
    pwl_pkg::t_point r_prev;
    logic            r_tag_vld, r_tag_first, r_tag_second, r_tag_last;

    logic signed [15:0] r_q;
    logic signed [15:0] r_x0, r_y0, r_xl, r_yl;
    logic signed [15:0] r_sx0, r_sy0, r_sx1, r_sy1;
    logic               r_direct;
    logic signed [15:0] r_direct_y;
    logic signed [33:0] r_prod;
    logic signed [16:0] r_dx;
    logic               r_neg;
    logic [15:0]        r_dvs;
    logic [15:0]        r_rem, n_rem;
    logic [33:0]        r_quo, n_quo;
    logic               r_stb;
    logic signed [15:0] r_res_y, n_res_y;
    logic               r_is_eval;

    logic               w_bracket;
    logic signed [16:0] w_dx, w_dy, w_dq;
    logic signed [33:0] w_prod;
    logic [33:0]        w_prod_mag;
    logic [16:0]        w_dx_mag;
    logic signed [34:0] w_qs, w_sum;
    logic signed [15:0] w_sat;

    // The bracket test pairs the entry just read with the one before it.
    assign w_bracket = ($signed(r_prev.x) <= r_q) && ($signed(r_rd_data.x) >= r_q);

    assign w_dx   = {r_sx1[15], r_sx1} - {r_sx0[15], r_sx0};
    assign w_dy   = {r_sy1[15], r_sy1} - {r_sy0[15], r_sy0};
    assign w_dq   = {r_q[15], r_q} - {r_sx0[15], r_sx0};
    assign w_prod = w_dy * w_dq;

    assign w_prod_mag = r_prod[33] ? 34'(-r_prod) : 34'(r_prod);
    assign w_dx_mag   = r_dx[16] ? 17'(-r_dx) : 17'(r_dx);

    // Two restoring steps per cycle; the remainder always stays below the divisor.
    always_comb begin
        logic [16:0] rem_t;
        n_rem = r_rem;
        n_quo = r_quo;
        for (int i = 0; i < 2; i++) begin
            rem_t = {n_rem, n_quo[33]};
            n_quo = {n_quo[32:0], 1'b0};
            if (rem_t >= {1'b0, r_dvs}) begin
                rem_t    = rem_t - {1'b0, r_dvs};
                n_quo[0] = 1'b1;
            end
            n_rem = rem_t[15:0];
        end
    end

    assign w_qs  = r_neg ? -$signed({1'b0, r_quo}) : $signed({1'b0, r_quo});
    assign w_sum = w_qs + $signed({{19{r_sy0[15]}}, r_sy0});

    always_comb begin
        if (w_sum > 35'sd32767) begin
            w_sat = 16'sh7FFF;
        end else if (w_sum < -35'sd32768) begin
            w_sat = -16'sh8000;
        end else begin
            w_sat = w_sum[15:0];
        end
    end

    always_comb begin
        if (i_cmd.ack) begin
            n_res_y = '0;
        end else if (r_direct) begin
            n_res_y = r_direct_y;
        end else begin
            n_res_y = w_sat;
        end
    end

    // Table memory: one write port for loads, one registered read port for scans.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_wr && (32'(i_point_index) < MAX_POINTS)) begin
            r_mem[AW'(i_point_index)] <= {i_point_x, i_point_y};
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag_vld <= 1'b0;
            r_stb     <= 1'b0;
        end else begin
            r_tag_vld <= i_cmd.rd_en;
            r_stb     <= i_cmd.ack | i_cmd.fin;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tag_first  <= i_cmd.tag_first;
        r_tag_second <= i_cmd.tag_second;
        r_tag_last   <= i_cmd.tag_last;

        if (i_cmd.capture) begin
            r_q        <= i_query_x;
            r_direct   <= 1'b1;
            r_direct_y <= '0;
        end

        if (r_tag_vld) begin
            r_prev <= r_rd_data;
            if (r_tag_first) begin
                r_x0 <= r_rd_data.x;
                r_y0 <= r_rd_data.y;
            end
            if (r_tag_last) begin
                r_xl <= r_rd_data.x;
                r_yl <= r_rd_data.y;
            end
            // Segment zero is the fallback; any later bracketing segment replaces it.
            if (r_tag_second || (!r_tag_first && w_bracket)) begin
                r_sx0 <= r_prev.x;
                r_sy0 <= r_prev.y;
                r_sx1 <= r_rd_data.x;
                r_sy1 <= r_rd_data.y;
            end
        end

        if (i_cmd.decide) begin
            r_prod <= w_prod;
            r_dx   <= w_dx;
            if (r_q <= r_x0) begin
                r_direct   <= 1'b1;
                r_direct_y <= r_y0;
            end else if (r_q >= r_xl) begin
                r_direct   <= 1'b1;
                r_direct_y <= r_yl;
            end else if (w_dx == '0) begin
                r_direct   <= 1'b1;
                r_direct_y <= r_sy0;
            end else begin
                r_direct <= 1'b0;
            end
        end

        if (i_cmd.div_load) begin
            r_neg <= r_prod[33] ^ r_dx[16];
            r_quo <= w_prod_mag;
            r_dvs <= w_dx_mag[15:0];
            r_rem <= '0;
        end else if (i_cmd.div_step) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end

        if (i_cmd.ack || i_cmd.fin) begin
            r_res_y   <= n_res_y;
            r_is_eval <= i_cmd.fin;
        end
    end

    assign o_status.direct = r_direct;
    assign o_result_stb    = r_stb;
    assign o_result_y      = r_res_y;
    assign o_is_evaluation = r_is_eval;

endmodule

[rtl/piecewise_linear_table_interp.sv]
// ----------------------------------------------------------------------------
// piecewise_linear_table_interp - breakpoint table with linear interpolation
// Loads (x, y) breakpoints and evaluates signed 16-bit queries against them.
// ----------------------------------------------------------------------------
// Usage: a word is taken on a rising edge with start high and busy low.
// i_op selects a load (i_point_index, i_point_x, i_point_y) or an evaluation
// (i_query_x). Every word gives one result word on o_result_y and
// o_is_evaluation, marked by o_result_stb for exactly one cycle; the receiver
// cannot stall, so it must take the word in that cycle.
// A load writes the table and is acknowledged in the next cycle without
// raising busy, so loads can follow back to back.
// An evaluation scans the first N table entries through the memory read port,
// one per cycle, then forms the product and runs a divider that retires two
// quotient bits per cycle. The divider is skipped when the query lands on a
// table end or a zero-width segment, and an empty table skips the scan too.
// The points-in-use register is written through i_cfg_wr_en/i_cfg_wr_data;
// the user must write it only while the block is idle, which the block itself
// does not enforce. Reset clears it and the sequencer; table contents are undefined until loaded.
// ----------------------------------------------------------------------------
module piecewise_linear_table_interp #(
    parameter int MAX_POINTS = pwl_pkg::MAX_POINTS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic                              i_op,
    input  logic [pwl_pkg::IDX_W-1:0]         i_point_index,
    input  logic signed [pwl_pkg::DATA_W-1:0] i_point_x,
    input  logic signed [pwl_pkg::DATA_W-1:0] i_point_y,
    input  logic signed [pwl_pkg::DATA_W-1:0] i_query_x,
    input  logic                              i_cfg_wr_en,
    input  logic [pwl_pkg::CFG_W-1:0]         i_cfg_wr_data,
    output logic                              o_result_stb,
    output logic signed [pwl_pkg::DATA_W-1:0] o_result_y,
    output logic                              o_is_evaluation
);

    pwl_pkg::t_dp_cmd              w_cmd;
    pwl_pkg::t_dp_status           w_status;
    logic [$clog2(MAX_POINTS)-1:0] w_rd_addr;

    pwl_ctrl #(
        .MAX_POINTS (MAX_POINTS)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_op          (i_op),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_status      (w_status),
        .o_cmd         (w_cmd),
        .o_rd_addr     (w_rd_addr)
    );

    pwl_dpath #(
        .MAX_POINTS (MAX_POINTS)
    ) u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .i_rd_addr       (w_rd_addr),
        .i_point_index   (i_point_index),
        .i_point_x       (i_point_x),
        .i_point_y       (i_point_y),
        .i_query_x       (i_query_x),
        .o_status        (w_status),
        .o_result_stb    (o_result_stb),
        .o_result_y      (o_result_y),
        .o_is_evaluation (o_is_evaluation)
    );

    // A load acknowledgment comes in the cycle after an accepted load word.
    a_ack_follows_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_stb && !o_is_evaluation) |->
            $past(start && !busy && (i_op == pwl_pkg::OP_LOAD)))
        else $error("load acknowledgment without an accepted load");

    // An evaluation result only comes out of the final sequencer step.
    a_eval_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_stb && o_is_evaluation) |-> $past(w_cmd.fin))
        else $error("evaluation result without a finishing step");

    // The table is only written while the sequencer is idle.
    a_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load_wr |-> !busy)
        else $error("table write while busy");

    // Scanning and dividing never overlap.
    a_scan_div_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_cmd.rd_en && (w_cmd.div_step || w_cmd.div_load)))
        else $error("table read during division");

endmodule

[verif/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench - self-checking bench for piecewise_linear_table_interp
// A short table of directed words is followed by random phases. Each phase
// loads a fresh ascending breakpoint table, sets the points-in-use register
// and mixes queries with single-point reloads. Every accepted word is run
// through a local interpolator and every result word is checked against it.
// ----------------------------------------------------------------------------
module testbench;

    typedef enum logic {ROW_WORD, ROW_CFG} t_row_kind;

    typedef struct {
        t_row_kind                         row_kind;
        logic                              op;
        logic [pwl_pkg::IDX_W-1:0]         idx;
        logic signed [pwl_pkg::DATA_W-1:0] px;
        logic signed [pwl_pkg::DATA_W-1:0] py;
        logic signed [pwl_pkg::DATA_W-1:0] qx;
        logic [pwl_pkg::CFG_W-1:0]         cfg;
        logic                              known;
        logic signed [pwl_pkg::DATA_W-1:0] known_y;
    } t_dir_row;

    typedef struct {
        logic signed [pwl_pkg::DATA_W-1:0] y;
        logic                              is_eval;
    } t_pwl_result;

    localparam int N_DIR = 27;
    localparam int N_PHASES = 12;
    localparam int MIXED_PER_PHASE = 64;

    logic                              i_clk = 1'b0;
    logic                              i_rst_n;
    logic                              start;
    logic                              busy;
    logic                              i_op;
    logic [pwl_pkg::IDX_W-1:0]         i_point_index;
    logic signed [pwl_pkg::DATA_W-1:0] i_point_x;
    logic signed [pwl_pkg::DATA_W-1:0] i_point_y;
    logic signed [pwl_pkg::DATA_W-1:0] i_query_x;
    logic                              i_cfg_wr_en;
    logic [pwl_pkg::CFG_W-1:0]         i_cfg_wr_data;
    logic                              o_result_stb;
    logic signed [pwl_pkg::DATA_W-1:0] o_result_y;
    logic                              o_is_evaluation;

    // Local copy of the breakpoint table and the points-in-use register.
    logic signed [pwl_pkg::DATA_W-1:0] tab_x [pwl_pkg::MAX_POINTS_DEF];
    logic signed [pwl_pkg::DATA_W-1:0] tab_y [pwl_pkg::MAX_POINTS_DEF];
    logic [pwl_pkg::CFG_W-1:0]         pts_cfg;

    t_pwl_result awaited_results [$];
    t_pwl_result oldest;
    t_dir_row    dir_rows [N_DIR];

    int  mismatch_count = 0;
    int  words_sent = 0;
    int  evals_sent = 0;
    int  results_checked = 0;
    int  cfg_writes = 0;
    logic no_gap_run = 1'b0;

    piecewise_linear_table_interp i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_op            (i_op),
        .i_point_index   (i_point_index),
        .i_point_x       (i_point_x),
        .i_point_y       (i_point_y),
        .i_query_x       (i_query_x),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .o_result_stb    (o_result_stb),
        .o_result_y      (o_result_y),
        .o_is_evaluation (o_is_evaluation)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        if (mismatch_count < 50) begin
            $display("MISMATCH at %0t: %s got %0d, expected %0d", $realtime, what, got, want);
        end
        mismatch_count++;
    endtask

    function automatic logic signed [pwl_pkg::DATA_W-1:0] interp_query(
        input logic signed [pwl_pkg::DATA_W-1:0] q
    );
        int     n;
        int     seg;
        int     i;
        longint x0, x1, y0, y1, dx, qq, v;
        n = (pts_cfg > 5'd16) ? 16 : int'(pts_cfg);
        if (n == 0) return '0;
        if (q <= tab_x[0]) return tab_y[0];
        if (q >= tab_x[n-1]) return tab_y[n-1];
        // The last segment whose ends bracket the query wins.
        seg = 0;
        for (i = 0; i + 1 < n; i++) begin
            if (tab_x[i] <= q && tab_x[i+1] >= q) seg = i;
        end
        x0 = tab_x[seg];
        x1 = tab_x[seg+1];
        y0 = tab_y[seg];
        y1 = tab_y[seg+1];
        qq = q;
        dx = x1 - x0;
        if (dx == 0) return tab_y[seg];
        v = y0 + ((y1 - y0) * (qq - x0)) / dx;
        if (v > 32767) return 16'sh7FFF;
        if (v < -32768) return 16'sh8000;
        return 16'(v);
    endfunction

    function automatic t_pwl_result interp_step(
        input logic                              op,
        input logic [pwl_pkg::IDX_W-1:0]         idx,
        input logic signed [pwl_pkg::DATA_W-1:0] px,
        input logic signed [pwl_pkg::DATA_W-1:0] py,
        input logic signed [pwl_pkg::DATA_W-1:0] qx
    );
        t_pwl_result r;
        r.is_eval = op;
        r.y = '0;
        if (op == pwl_pkg::OP_LOAD) begin
            tab_x[idx] = px;
            tab_y[idx] = py;
        end else begin
            r.y = interp_query(qx);
        end
        return r;
    endfunction

    // Offers one word after a random gap and records its expected result once
    // the block has taken it.
    task automatic send_word(
        input logic                              op,
        input logic [pwl_pkg::IDX_W-1:0]         idx,
        input logic signed [pwl_pkg::DATA_W-1:0] px,
        input logic signed [pwl_pkg::DATA_W-1:0] py,
        input logic signed [pwl_pkg::DATA_W-1:0] qx,
        input logic                              known,
        input logic signed [pwl_pkg::DATA_W-1:0] known_y
    );
        int          gap;
        t_pwl_result r;
        if (words_sent % 16 == 0) no_gap_run = ($urandom_range(0, 3) == 0);
        gap = no_gap_run ? 0 : int'($urandom_range(0, 18));
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start         <= 1'b1;
        i_op          <= op;
        i_point_index <= idx;
        i_point_x     <= px;
        i_point_y     <= py;
        i_query_x     <= qx;
        do @(posedge i_clk); while (busy);
        r = interp_step(op, idx, px, py, qx);
        if (known) r.y = known_y;
        awaited_results.push_back(r);
        words_sent++;
        if (op == pwl_pkg::OP_EVAL) evals_sent++;
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        while (awaited_results.size() != 0 || busy) @(posedge i_clk);
    endtask

    task automatic write_points_in_use(input logic [pwl_pkg::CFG_W-1:0] v);
        wait_drained();
        repeat (2) @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        pts_cfg = v;
        cfg_writes++;
        i_cfg_wr_en   <= 1'b0;
        i_cfg_wr_data <= pwl_pkg::CFG_W'($urandom);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_result_stb) begin
            if (awaited_results.size() == 0) begin
                report_mismatch("unexpected result word, y", int'(o_result_y), 0);
            end else begin
                oldest = awaited_results.pop_front();
                if (o_result_y !== oldest.y) begin
                    report_mismatch("result_y", int'(o_result_y), int'(oldest.y));
                end
                if (o_is_evaluation !== oldest.is_eval) begin
                    report_mismatch("is_evaluation", int'(o_is_evaluation),
                                    int'(oldest.is_eval));
                end
                results_checked++;
            end
        end
    end

    initial begin
        #5_000_000;
        $display("TIMEOUT: %0d results still awaited", awaited_results.size());
        $display("end of test: mismatches");
        $finish;
    end

    initial begin
        int                                ph, s, k, n, sel, seg_i, lo, hi;
        int                                step_max, base_x;
        logic [pwl_pkg::CFG_W-1:0]         pick;
        logic signed [pwl_pkg::DATA_W-1:0] yv, qv, xv;
        logic [pwl_pkg::IDX_W-1:0]         slot;
        logic [pwl_pkg::CFG_W-1:0]         first_picks [6];

        first_picks = '{5'd16, 5'd31, 5'd0, 5'd1, 5'd2, 5'd17};
        for (s = 0; s < pwl_pkg::MAX_POINTS_DEF; s++) begin
            tab_x[s] = '0;
            tab_y[s] = '0;
        end
        pts_cfg = '0;

        // Loads are acknowledged with zero; the ends and the empty table give
        // values that can be read straight off the breakpoints.
        dir_rows = '{
            '{ROW_WORD, pwl_pkg::OP_EVAL, 4'd0, 16'sd0, 16'sd0, 16'sd0, 5'd0, 1'b1, 16'sd0},
            '{ROW_WORD, pwl_pkg::OP_EVAL, 4'd0, 16'sd0, 16'sd0, 16'sh8000, 5'd0, 1'b1, 16'sd0},
            '{ROW_WORD, pwl_pkg::OP_EVAL, 4'd0, 16'sd0, 16'sd0, 16'sh7FFF, 5'd0, 1'b1, 16'sd0},
            '{ROW_WORD, pwl_pkg::OP_LOAD, 4'd0, 16'sh8000, 16'sh7FFF, 16'sd0, 5'd0, 1'b1,
              16'sd0},
            '{ROW_WORD, pwl_pkg::OP_LOAD, 4'd1, -16'sd100, 16'sh8000, 16'sd0, 5'd0, 1'b1,
              16'sd0},
            '{ROW_WORD, pwl_pkg::OP_LOAD, 4'd2, 16'sd100, 16'sd1000, 16'sd0, 5'd0, 1'b1,
              16'sd0},
            '{ROW_WORD, pwl_pkg::OP_LOAD, 4'd3, 16'sh7FFF, 16'sh8000, 16'sd0, 5'd0, 1'b1,
              16'sd0},
            '{ROW_WORD, pwl_pkg::OP_LOAD, 4'd15, -16'sd1, -16'sd1, 16'sh7FFF, 5'd0, 1'b1,
              16'sd0},
            '{ROW_CFG, pwl_pkg::OP_LOAD, 4'd0, 16'sd0, 16'sd0, 16'sd0, 5'd1, 1'b0, 16'sd0},
            '{ROW_WORD, pwl_pkg::OP_EVAL, 4'd0, 16'sd0, 16'sd0, 16'sh7FFF, 5'd0, 1'b1,
              16'sh7FFF},
            '{ROW_WORD, pwl_pkg::OP_EVAL, 4'd0, 16'sd0, 16'sd0, 16'sh8000, 5'd0, 1'b1,
              16'sh7FFF},
            '{ROW_CFG, pwl_pkg::OP_LOAD, 4'd0, 16'sd0, 16'sd0, 16'sd0, 5'd4, 1'b0, 16'sd0},
            '{ROW_WORD, pwl_pkg::OP_EVAL, 4'd0, 16'sd0, 16'sd0, 16'sh8000, 5'd0, 1'b1,
              16'sh7FFF},
            '{ROW_WORD, pwl_pkg::OP_EVAL, 4'd0, 16'sd0, 16'sd0, 16'sh7FFF, 5'd0, 1'b1,
              16'sh8000},
            '{ROW_WORD, pwl_pkg::OP_EVAL, 4'd0, 16'sd0, 16'sd0, -16'sd100, 5'd0, 1'b0, 16'sd0},
            '{ROW_WORD, pwl_pkg::OP_EVAL, 4'd0, 16'sd0, 16'sd0, 16'sd0, 5'd0, 1'b0, 16'sd0},
            '{ROW_WORD, pwl_pkg::OP_EVAL, 4'd0, 16'sd0, 16'sd0, -16'sd32767, 5'd0, 1'b0,
              16'sd0},
            '{ROW_WORD, pwl_pkg::OP_EVAL, 4'd0, 16'sd0, 16'sd0, 16'sd32766, 5'd0, 1'b0,
              16'sd0},
            '{ROW_WORD, pwl_pkg::OP_LOAD, 4'd2, -16'sd100, 16'sd5, 16'sd0, 5'd0, 1'b1, 16'sd0},
            '{ROW_WORD, pwl_pkg::OP_EVAL, 4'd0, 16'sd0, 16'sd0, -16'sd100, 5'd0, 1'b0, 16'sd0},
            '{ROW_WORD, pwl_pkg::OP_EVAL, 4'd0, 16'sd0, 16'sd0, -16'sd50, 5'd0, 1'b0, 16'sd0},
            '{ROW_WORD, pwl_pkg::OP_LOAD, 4'd1, 16'sd200, -16'sd7, 16'sd0, 5'd0, 1'b1, 16'sd0},
            '{ROW_WORD, pwl_pkg::OP_EVAL, 4'd0, 16'sd0, 16'sd0, 16'sd150, 5'd0, 1'b0, 16'sd0},
            '{ROW_CFG, pwl_pkg::OP_LOAD, 4'd0, 16'sd0, 16'sd0, 16'sd0, 5'd2, 1'b0, 16'sd0},
            '{ROW_WORD, pwl_pkg::OP_EVAL, 4'd0, 16'sd0, 16'sd0, 16'sd0, 5'd0, 1'b0, 16'sd0},
            '{ROW_CFG, pwl_pkg::OP_LOAD, 4'd0, 16'sd0, 16'sd0, 16'sd0, 5'd0, 1'b0, 16'sd0},
            '{ROW_WORD, pwl_pkg::OP_EVAL, 4'd0, 16'sd0, 16'sd0, 16'sd5, 5'd0, 1'b1, 16'sd0}
        };

        i_rst_n       <= 1'b0;
        start         <= 1'b0;
        i_op          <= pwl_pkg::OP_LOAD;
        i_point_index <= '0;
        i_point_x     <= '0;
        i_point_y     <= '0;
        i_query_x     <= '0;
        i_cfg_wr_en   <= 1'b0;
        i_cfg_wr_data <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (k = 0; k < N_DIR; k++) begin
            if (dir_rows[k].row_kind == ROW_CFG) begin
                write_points_in_use(dir_rows[k].cfg);
            end else begin
                send_word(dir_rows[k].op, dir_rows[k].idx, dir_rows[k].px,
                          dir_rows[k].py, dir_rows[k].qx, dir_rows[k].known,
                          dir_rows[k].known_y);
            end
        end

        for (ph = 0; ph < N_PHASES; ph++) begin
            // Fresh ascending table; a few phases pack the points tightly so
            // that equal abscissas show up.
            step_max = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 8))
                                                   : int'($urandom_range(1, 4095));
            base_x = -32768 + int'($urandom_range(0, 65535 - 15 * step_max));
            for (s = 0; s < pwl_pkg::MAX_POINTS_DEF; s++) begin
                if (s > 0) base_x += int'($urandom_range(0, step_max));
                case ($urandom_range(0, 7))
                    0: yv = 16'sh8000;
                    1: yv = 16'sh7FFF;
                    default: yv = 16'($urandom);
                endcase
                send_word(pwl_pkg::OP_LOAD, pwl_pkg::IDX_W'(s), 16'(base_x), yv,
                          16'($urandom), 1'b0, '0);
            end

            pick = (ph < 6) ? first_picks[ph] : pwl_pkg::CFG_W'($urandom_range(0, 31));
            write_points_in_use(pick);
            n = (pick > 5'd16) ? 16 : int'(pick);

            for (k = 0; k < MIXED_PER_PHASE; k++) begin
                if ($urandom_range(0, 3) == 0) begin
                    // Half of the reloads keep the abscissa and so the order.
                    slot = pwl_pkg::IDX_W'($urandom);
                    xv = $urandom_range(0, 1) ? tab_x[slot] : 16'($urandom);
                    send_word(pwl_pkg::OP_LOAD, slot, xv, 16'($urandom), 16'($urandom),
                              1'b0, '0);
                end else begin
                    sel = int'($urandom_range(0, 9));
                    if (sel < 4 && n >= 2) begin
                        seg_i = int'($urandom_range(0, n - 2));
                        lo = (tab_x[seg_i] < tab_x[seg_i+1]) ? tab_x[seg_i] : tab_x[seg_i+1];
                        hi = (tab_x[seg_i] < tab_x[seg_i+1]) ? tab_x[seg_i+1] : tab_x[seg_i];
                        qv = 16'(lo + int'($urandom_range(0, hi - lo)));
                    end else if (sel < 7) begin
                        slot = (n == 0) ? pwl_pkg::IDX_W'($urandom)
                                        : pwl_pkg::IDX_W'($urandom_range(0, n - 1));
                        qv = tab_x[slot];
                        if (sel == 6) qv = $urandom_range(0, 1) ? qv + 16'sd1 : qv - 16'sd1;
                    end else if (sel == 7) begin
                        qv = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
                    end else begin
                        qv = 16'($urandom);
                    end
                    send_word(pwl_pkg::OP_EVAL, pwl_pkg::IDX_W'($urandom), 16'($urandom),
                              16'($urandom), qv, 1'b0, '0);
                end
            end
        end

        wait_drained();
        repeat (40) @(posedge i_clk);

        $display("Ran %0d words (%0d evaluations, %0d loads) over %0d register writes,",
                 words_sent, evals_sent, words_sent - evals_sent, cfg_writes);
        $display("checked %0d result words, %0d mismatches.", results_checked, mismatch_count);
        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
